>>> rtl/core/pba_pkg.sv
// shared types and constants for the page bitmap allocator
package pba_pkg;

  localparam int PAGE_W     = 15;
  localparam int LOC_WORD_W = 12;
  localparam int LOC_BIT_W  = 6;

  typedef enum logic [1:0] {
    FN_MARK_USED = 2'd0,
    FN_MARK_FREE = 2'd1,
    FN_QUERY     = 2'd2,
    FN_FIND      = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOCATE,
    ST_ACCESS,
    ST_SCAN,
    ST_PLACE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                  valid;
    logic [LOC_WORD_W-1:0] word;
    logic [LOC_BIT_W-1:0]  bit_idx;
  } loc_t;

endpackage

>>> rtl/core/pba_mem.sv
// bitmap word memory, one write port and one registered read port
module pba_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/pba_locate.sv
// page index to word and bit position, reciprocal divide over three stages
module pba_locate #(
  parameter int NUM_PAGES = 32768,
  parameter int WORD_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [pba_pkg::PAGE_W-1:0] page,
  output logic                       done,
  output pba_pkg::loc_t              loc
);

  localparam int RECIP = 32768 / WORD_BITS;

  logic [27:0]                        prod1;
  logic [18:0]                        rem;
  logic                               v1;
  logic                               v2;
  logic [pba_pkg::LOC_WORD_W-1:0]     q_a;
  logic [pba_pkg::LOC_WORD_W-1:0]     q_b;
  logic [pba_pkg::PAGE_W-1:0]         page_a;
  logic [pba_pkg::PAGE_W-1:0]         page_b;
  logic [18:0]                        prod2;

  assign prod1 = 28'(page) * 28'(RECIP);
  assign rem   = 19'(page_b) - prod2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start;
      v2   <= v1;
      done <= v2;
    end
  end

  // quotient estimate is exact or one low, fixed in the last stage
  always_ff @(posedge clk) begin
    q_a    <= prod1[26:15];
    page_a <= page;
    q_b    <= q_a;
    page_b <= page_a;
    prod2  <= 19'(q_a) * 19'(WORD_BITS);
    loc.valid <= 17'(page_b) < 17'(NUM_PAGES);
    if (rem >= 19'(WORD_BITS)) begin
      loc.word    <= q_b + 1'b1;
      loc.bit_idx <= pba_pkg::LOC_BIT_W'(rem - 19'(WORD_BITS));
    end else begin
      loc.word    <= q_b;
      loc.bit_idx <= pba_pkg::LOC_BIT_W'(rem);
    end
  end

endmodule

>>> rtl/core/page_bitmap_allocator.sv
// page bitmap allocator top level: request handling, bitmap update and free page scan
//
// one usage bit per page, packed WORD_BITS pages to a word in an on-chip memory.
// request channel (req_valid, req_stall, func, page): func 0 marks a page used,
// 1 marks it free, 2 asks whether it is used, 3 finds the lowest free page
// without marking it. every request gives exactly one response item on
// (rsp_valid, rsp_stall, in_use, found, free_page); unused fields read zero.
// one request is worked on at a time. mark and query run the page to word divide,
// which starts at the accept edge, then a memory read and the update or test, and
// then load the response register; a page at or beyond NUM_PAGES skips the memory.
// find reads one bitmap word per cycle from word 0 and stops at the first word
// with a clear bit; at most WORD_COUNT words are read, and a hit then passes
// through the place step before the response register is loaded.
// after reset the block sweeps the memory to zero, one word per cycle, over all
// WORD_COUNT words (1024 at the defaults) with req_stall high.
// a new request is taken while the previous response still waits in the
// output register; a held rsp_stall keeps that response and the next one waits.
module page_bitmap_allocator #(
  parameter int NUM_PAGES = 32768,
  parameter int WORD_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  logic [1:0]                 func,
  input  logic [pba_pkg::PAGE_W-1:0] page,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output logic                       in_use,
  output logic                       found,
  output logic [pba_pkg::PAGE_W-1:0] free_page
);

  localparam int WORD_COUNT = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int WIDX       = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int BW         = $clog2(WORD_BITS);
  localparam int PLW        = WIDX + 7;
  localparam logic [WIDX-1:0] LAST = WIDX'(WORD_COUNT - 1);

  pba_pkg::state_t state;
  pba_pkg::state_t state_next;

  pba_pkg::func_t             func_q;
  logic [WIDX-1:0]            clr_addr;
  logic [WIDX-1:0]            scan_addr;
  logic [WIDX-1:0]            hit_word;
  logic [BW-1:0]              hit_bit;
  pba_pkg::loc_t              loc_q;
  logic                       res_in_use;
  logic                       res_found;
  logic [pba_pkg::PAGE_W-1:0] res_page;

  logic                       accept;
  logic                       rsp_load;
  logic                       loc_start;
  logic                       loc_done;
  pba_pkg::loc_t              loc;
  logic                       mem_we;
  logic [WIDX-1:0]            mem_waddr;
  logic [WORD_BITS-1:0]       mem_wdata;
  logic                       mem_re;
  logic [WIDX-1:0]            mem_raddr;
  logic [WORD_BITS-1:0]       mem_rdata;
  logic [BW:0]                scan_res;
  logic                       scan_hit;
  logic [BW-1:0]              bit_sel;
  logic [WORD_BITS-1:0]       bit_mask;
  logic [PLW-1:0]             place_page;

  function automatic logic [BW:0] first_zero(input logic [WORD_BITS-1:0] w);
    logic [BW:0] r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) begin
        r = {1'b1, BW'(i)};
      end
    end
    return r;
  endfunction

  assign accept     = req_valid && !req_stall;
  assign rsp_load   = (state == pba_pkg::ST_DONE) && (!rsp_valid || !rsp_stall);
  assign scan_res   = first_zero(mem_rdata);
  assign scan_hit   = scan_res[BW];
  assign bit_sel    = loc_q.bit_idx[BW-1:0];
  assign bit_mask   = WORD_BITS'(1) << bit_sel;
  assign place_page = PLW'(hit_word) * PLW'(WORD_BITS) + PLW'(hit_bit);

  pba_locate #(
    .NUM_PAGES(NUM_PAGES),
    .WORD_BITS(WORD_BITS)
  ) u_locate (
    .clk  (clk),
    .rst  (rst),
    .start(loc_start),
    .page (page),
    .done (loc_done),
    .loc  (loc)
  );

  pba_mem #(
    .DEPTH(WORD_COUNT),
    .WIDTH(WORD_BITS),
    .AW   (WIDX)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      pba_pkg::ST_CLEAR: begin
        if (clr_addr == LAST) begin
          state_next = pba_pkg::ST_IDLE;
        end
      end
      pba_pkg::ST_IDLE: begin
        if (accept) begin
          if (func == pba_pkg::FN_FIND) begin
            state_next = pba_pkg::ST_SCAN;
          end else begin
            state_next = pba_pkg::ST_LOCATE;
          end
        end
      end
      pba_pkg::ST_LOCATE: begin
        if (loc_done) begin
          state_next = loc.valid ? pba_pkg::ST_ACCESS : pba_pkg::ST_DONE;
        end
      end
      pba_pkg::ST_ACCESS: begin
        state_next = pba_pkg::ST_DONE;
      end
      pba_pkg::ST_SCAN: begin
        if (scan_hit) begin
          state_next = pba_pkg::ST_PLACE;
        end else if (scan_addr == LAST) begin
          state_next = pba_pkg::ST_DONE;
        end
      end
      pba_pkg::ST_PLACE: begin
        state_next = pba_pkg::ST_DONE;
      end
      pba_pkg::ST_DONE: begin
        if (rsp_load) begin
          state_next = pba_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pba_pkg::ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    req_stall = 1'b1;
    loc_start = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = WIDX'(loc_q.word);
    mem_wdata = mem_rdata | bit_mask;
    mem_re    = 1'b0;
    mem_raddr = '0;
    case (state)
      pba_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      pba_pkg::ST_IDLE: begin
        req_stall = 1'b0;
        loc_start = accept && (func != pba_pkg::FN_FIND);
        mem_re    = accept && (func == pba_pkg::FN_FIND);
      end
      pba_pkg::ST_LOCATE: begin
        mem_re    = loc_done && loc.valid;
        mem_raddr = WIDX'(loc.word);
      end
      pba_pkg::ST_ACCESS: begin
        mem_we = (func_q == pba_pkg::FN_MARK_USED) || (func_q == pba_pkg::FN_MARK_FREE);
        if (func_q == pba_pkg::FN_MARK_FREE) begin
          mem_wdata = mem_rdata & ~bit_mask;
        end
      end
      pba_pkg::ST_SCAN: begin
        mem_re    = !scan_hit && (scan_addr != LAST);
        mem_raddr = scan_addr + 1'b1;
      end
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pba_pkg::ST_CLEAR;
      clr_addr  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == pba_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_q    <= pba_pkg::func_t'(func);
      scan_addr <= '0;
    end
    if (state == pba_pkg::ST_LOCATE && loc_done) begin
      loc_q      <= loc;
      res_in_use <= 1'b0;
      res_found  <= 1'b0;
      res_page   <= '0;
    end
    if (state == pba_pkg::ST_ACCESS) begin
      res_in_use <= (func_q == pba_pkg::FN_QUERY) && mem_rdata[bit_sel];
    end
    if (state == pba_pkg::ST_SCAN) begin
      scan_addr  <= scan_addr + 1'b1;
      hit_word   <= scan_addr;
      hit_bit    <= scan_res[BW-1:0];
      res_in_use <= 1'b0;
      res_found  <= 1'b0;
      res_page   <= '0;
    end
    if (state == pba_pkg::ST_PLACE) begin
      if (place_page < PLW'(NUM_PAGES)) begin
        res_found <= 1'b1;
        res_page  <= pba_pkg::PAGE_W'(place_page);
      end
    end
    if (rsp_load) begin
      in_use    <= res_in_use;
      found     <= res_found;
      free_page <= res_page;
    end
  end

endmodule

>>> rtl/core/pba_checker.sv
// port level checks for the page bitmap allocator and its bind
module pba_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_stall,
  input logic                       rsp_valid,
  input logic                       rsp_stall,
  input logic                       in_use,
  input logic                       found,
  input logic [pba_pkg::PAGE_W-1:0] free_page
);

  // memory sweep holds off requests right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> req_stall)
    else $error("request taken during memory sweep");

  // one item in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("second item taken back to back");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(in_use) && $stable(found)
      && $stable(free_page))
    else $error("stalled response changed");

  a_no_page_when_not_found: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !found |-> free_page == '0)
    else $error("free page given without found");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(in_use && found))
    else $error("in_use and found both set");

endmodule

bind page_bitmap_allocator pba_checker u_pba_checker (
  .clk      (clk),
  .rst      (rst),
  .req_valid(req_valid),
  .req_stall(req_stall),
  .rsp_valid(rsp_valid),
  .rsp_stall(rsp_stall),
  .in_use   (in_use),
  .found    (found),
  .free_page(free_page)
);
